// File: rtl/bus_page_offset_mirror_defines.svh
// Assertion macros used by the checker file of bus_page_offset_mirror.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef BUS_PAGE_OFFSET_MIRROR_DEFINES_SVH
`define BUS_PAGE_OFFSET_MIRROR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BPOM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bus_page_offset_mirror: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BPOM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bus_page_offset_mirror: assertion failed");

`endif

// File: rtl/bpom_pkg.sv
// Package of bus_page_offset_mirror: beat types, register indexes, modes and state codes.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package bpom_pkg;

    localparam int ADDR_W = 24;
    localparam int SIZE_W = 25;
    localparam int CNT_W  = 5;

    localparam logic [CNT_W-1:0]  LAST_STEP         = 5'd23;
    localparam logic [SIZE_W-1:0] DEVICE_SIZE_RESET = 25'h100_0000;
    localparam logic [7:0]        LAST_PAGE         = 8'hFF;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_MAP_MODE    = 3'd0;
    localparam logic [2:0] REG_BANK_LOW    = 3'd1;
    localparam logic [2:0] REG_BANK_HIGH   = 3'd2;
    localparam logic [2:0] REG_PAGE_LOW    = 3'd3;
    localparam logic [2:0] REG_PAGE_HIGH   = 3'd4;
    localparam logic [2:0] REG_BASE_OFFSET = 3'd5;
    localparam logic [2:0] REG_WINDOW_SIZE = 3'd6;
    localparam logic [2:0] REG_DEVICE_SIZE = 3'd7;

    // Page numbering modes.
    localparam logic [1:0] MODE_DIRECT = 2'd0;
    localparam logic [1:0] MODE_LINEAR = 2'd1;
    localparam logic [1:0] MODE_SHADOW = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INDEX,
        ST_MOD,
        ST_SUM,
        ST_FOLD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [7:0] bank;
        logic [7:0] page;
    } in_beat_t;

    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] mapped_base;
        logic              overflow;
    } out_beat_t;

    // Operands and result of the shared subtractor.
    typedef struct packed {
        logic [SIZE_W:0] a;
        logic [SIZE_W:0] b;
    } sub_req_t;

    typedef struct packed {
        logic [SIZE_W:0] diff;
        logic            ge;
    } sub_rsp_t;

endpackage

// File: rtl/bpom_sub_unit.sv
// Shared 26-bit subtract and compare unit of bus_page_offset_mirror.
// Depends on bpom_pkg for the request and response structs.
`timescale 1ns / 1ps

module bpom_sub_unit (
    input  bpom_pkg::sub_req_t req,
    output bpom_pkg::sub_rsp_t rsp
);

    logic [bpom_pkg::SIZE_W+1:0] wide_diff;

    // One extra bit on top catches the borrow; no borrow means a >= b.
    always_comb
    begin
        wide_diff = {1'b0, req.a} - {1'b0, req.b};
        rsp.diff  = wide_diff[bpom_pkg::SIZE_W:0];
        rsp.ge    = ~wide_diff[bpom_pkg::SIZE_W+1];
    end

endmodule

// File: rtl/bus_page_offset_mirror.sv
// Top level of bus_page_offset_mirror: configuration registers, sequencer and datapath.
// Depends on bpom_pkg and instantiates bpom_sub_unit.
//
//  Channel   Direction  Handshake              Beat
//  in        input      in_valid / in_stall    bank, page
//  out       output     out_valid / out_stall  hit, mapped_base, overflow
//  cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A beat is taken only in idle; a miss or a direct-mode lookup goes from the index state to
// the done state, which registers the result. Linear and shadow lookups pass through up to 24
// restoring steps of the window modulo, the sum state and up to 24 mirror fold steps on the
// one shared subtractor. A finished result waits in the done state while the output register
// holds a stalled beat, and the next input beat is taken once the result is registered. Reset
// is asynchronous and loads the register defaults; cfg_ready is always high.
`timescale 1ns / 1ps

module bus_page_offset_mirror (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  bpom_pkg::in_beat_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output bpom_pkg::out_beat_t  out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [24:0]          cfg_data
);

    localparam int AW = bpom_pkg::ADDR_W;
    localparam int SW = bpom_pkg::SIZE_W;

    // Configuration registers.
    logic [1:0]    map_mode_reg;
    logic [7:0]    bank_low_reg;
    logic [7:0]    bank_high_reg;
    logic [7:0]    page_low_reg;
    logic [7:0]    page_high_reg;
    logic [AW-1:0] base_offset_reg;
    logic [SW-1:0] window_size_reg;
    logic [SW-1:0] device_size_reg;

    // Sequencer and working registers.
    bpom_pkg::state_t state_reg, state_next;
    logic [bpom_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]    bank_reg, bank_next;
    logic [7:0]    page_reg, page_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [SW-1:0] rem_reg, rem_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [SW-1:0] size_reg, size_next;
    logic [AW-1:0] base_reg, base_next;
    logic          hit_reg, hit_next;
    logic          ovf_reg, ovf_next;
    logic          out_valid_reg, out_valid_next;
    bpom_pkg::out_beat_t out_data_reg, out_data_next;

    bpom_pkg::sub_req_t sub_req;
    bpom_pkg::sub_rsp_t sub_rsp;

    logic          in_window;
    logic [7:0]    bank_diff;
    logic [8:0]    row_len;
    logic [16:0]   page_count;
    logic [SW:0]   rem_shift;
    logic [SW-1:0] bit_val;
    logic [SW:0]   size_less_bit;
    logic          size_gt_bit;
    logic [SW-1:0] sum;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != bpom_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_mode_reg    <= bpom_pkg::MODE_DIRECT;
            bank_low_reg    <= 8'd0;
            bank_high_reg   <= bpom_pkg::LAST_PAGE;
            page_low_reg    <= 8'd0;
            page_high_reg   <= bpom_pkg::LAST_PAGE;
            base_offset_reg <= '0;
            window_size_reg <= '0;
            device_size_reg <= bpom_pkg::DEVICE_SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bpom_pkg::REG_MAP_MODE:    map_mode_reg    <= cfg_data[1:0];
                bpom_pkg::REG_BANK_LOW:    bank_low_reg    <= cfg_data[7:0];
                bpom_pkg::REG_BANK_HIGH:   bank_high_reg   <= cfg_data[7:0];
                bpom_pkg::REG_PAGE_LOW:    page_low_reg    <= cfg_data[7:0];
                bpom_pkg::REG_PAGE_HIGH:   page_high_reg   <= cfg_data[7:0];
                bpom_pkg::REG_BASE_OFFSET: base_offset_reg <= cfg_data[AW-1:0];
                bpom_pkg::REG_WINDOW_SIZE: window_size_reg <= cfg_data;
                bpom_pkg::REG_DEVICE_SIZE: device_size_reg <= cfg_data;
                default:                   map_mode_reg    <= map_mode_reg;
            endcase
        end
    end

    // The one subtractor serves both the modulo steps and the fold compares.
    bpom_sub_unit u_sub (
        .req (sub_req),
        .rsp (sub_rsp)
    );

    // Window test and page index, evaluated on the captured beat.
    always_comb
    begin
        in_window = (bank_reg >= bank_low_reg) && (bank_reg <= bank_high_reg) &&
                    (page_reg >= page_low_reg) && (page_reg <= page_high_reg) &&
                    (map_mode_reg != bpom_pkg::MODE_UNUSED);
        bank_diff  = bank_reg - bank_low_reg;
        row_len    = {1'b0, page_high_reg} - {1'b0, page_low_reg} + 9'd1;
        page_count = 17'(bank_diff * row_len) + {9'd0, page_reg - page_low_reg};
    end

    // Operand selection for the shared unit and the small fold arithmetic.
    always_comb
    begin
        rem_shift     = {rem_reg, idx_reg[cnt_reg]};
        bit_val       = SW'(1) << cnt_reg;
        size_less_bit = {1'b0, size_reg} - {1'b0, bit_val};
        size_gt_bit   = ~size_less_bit[SW] && (size_less_bit[SW-1:0] != '0);
        sum           = {1'b0, base_offset_reg} + {1'b0, idx_reg};
        if (state_reg == bpom_pkg::ST_FOLD)
        begin
            sub_req.a = {2'b00, addr_reg};
            sub_req.b = {1'b0, size_reg};
        end
        else
        begin
            sub_req.a = rem_shift;
            sub_req.b = {1'b0, window_size_reg};
        end
    end

    // Sequencer: next state and next values of the working registers.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        bank_next      = bank_reg;
        page_next      = page_reg;
        idx_next       = idx_reg;
        rem_next       = rem_reg;
        addr_next      = addr_reg;
        size_next      = size_reg;
        base_next      = base_reg;
        hit_next       = hit_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            bpom_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    bank_next  = in_data.bank;
                    page_next  = in_data.page;
                    state_next = bpom_pkg::ST_INDEX;
                end
            end
            bpom_pkg::ST_INDEX:
            begin
                hit_next  = in_window;
                ovf_next  = 1'b0;
                base_next = '0;
                addr_next = '0;
                rem_next  = '0;
                cnt_next  = bpom_pkg::LAST_STEP;
                if (map_mode_reg == bpom_pkg::MODE_LINEAR)
                begin
                    idx_next = {page_count[15:0], 8'h00};
                end
                else
                begin
                    idx_next = {bank_diff, page_reg, 8'h00};
                end
                if (!in_window)
                begin
                    state_next = bpom_pkg::ST_DONE;
                end
                else if (map_mode_reg == bpom_pkg::MODE_DIRECT)
                begin
                    addr_next  = {bank_reg, page_reg, 8'h00};
                    state_next = bpom_pkg::ST_DONE;
                end
                else if (window_size_reg != '0)
                begin
                    state_next = bpom_pkg::ST_MOD;
                end
                else
                begin
                    state_next = bpom_pkg::ST_SUM;
                end
            end
            bpom_pkg::ST_MOD:
            begin
                // One restoring step of index modulo window size.
                rem_next = sub_rsp.ge ? sub_rsp.diff[SW-1:0] : rem_shift[SW-1:0];
                if (cnt_reg == '0)
                begin
                    idx_next   = rem_next[AW-1:0];
                    state_next = bpom_pkg::ST_SUM;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            bpom_pkg::ST_SUM:
            begin
                ovf_next  = sum[AW];
                addr_next = sum[AW-1:0];
                size_next = device_size_reg;
                cnt_next  = bpom_pkg::LAST_STEP;
                if (device_size_reg == '0)
                begin
                    addr_next  = '0;
                    state_next = bpom_pkg::ST_DONE;
                end
                else
                begin
                    state_next = bpom_pkg::ST_FOLD;
                end
            end
            bpom_pkg::ST_FOLD:
            begin
                // Strip a set address bit while the address is not below the size.
                if (sub_rsp.ge && addr_reg[cnt_reg])
                begin
                    addr_next[cnt_reg] = 1'b0;
                    if (size_gt_bit)
                    begin
                        size_next          = size_less_bit[SW-1:0];
                        base_next[cnt_reg] = 1'b1;
                    end
                end
                if (cnt_reg == '0)
                begin
                    state_next = bpom_pkg::ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            bpom_pkg::ST_DONE:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.hit         = hit_reg;
                    out_data_next.overflow    = hit_reg && ovf_reg;
                    out_data_next.mapped_base = hit_reg ? (base_reg + addr_reg) : '0;
                    state_next                = bpom_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bpom_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bpom_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge clk)
    begin
        bank_reg     <= bank_next;
        page_reg     <= page_next;
        idx_reg      <= idx_next;
        rem_reg      <= rem_next;
        addr_reg     <= addr_next;
        size_reg     <= size_next;
        base_reg     <= base_next;
        hit_reg      <= hit_next;
        ovf_reg      <= ovf_next;
        out_data_reg <= out_data_next;
    end

endmodule

// File: rtl/bpom_checker.sv
// Port-level checker of bus_page_offset_mirror, bound to the top level.
// Depends on bpom_pkg and the assertion macros in bus_page_offset_mirror_defines.svh.
`timescale 1ns / 1ps
`include "bus_page_offset_mirror_defines.svh"

module bpom_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input bpom_pkg::out_beat_t out_data
);

    // A stalled result beat stays and holds its payload.
    `BPOM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

    // A miss reports neither a base nor an overflow.
    `BPOM_ASSERT_NOW(a_miss_clean, clk, rst_n, out_valid && !out_data.hit, (out_data.mapped_base == '0) && !out_data.overflow)

    // The block is busy in the cycle after it takes a beat.
    `BPOM_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && !in_stall, in_stall)

    // One item gives one result, so a taken result is not followed at once by another.
    `BPOM_ASSERT_NEXT(a_single_result, clk, rst_n, out_valid && !out_stall, !out_valid)

endmodule

bind bus_page_offset_mirror bpom_checker u_bpom_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
